@@ hw/rtl/vt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt_pkg: shared types and constants of the 4x4 vertex transform
// Word formats of both channels, mode codes and datapath widths.
// ----------------------------------------------------------------------------
package vt_pkg;

  localparam logic [1:0] OP_PROJ3 = 2'd0;
  localparam logic [1:0] OP_AFF3  = 2'd1;
  localparam logic [1:0] OP_HOMO4 = 2'd2;
  localparam logic [1:0] OP_AFF4  = 2'd3;

  // Four floored 64-bit products summed exactly.
  localparam int SUM_W   = 66;
  // Quotient bits kept by the divider; anything at or above 2^33 saturates.
  localparam int QB      = 33;
  localparam int DIV_LAT = QB + 1;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } vt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               divide_by_zero;
    logic               saturated;
  } vt_out_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
    logic               dz;
  } vt_lane_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/vt_row_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt_row_lane: one matrix row times the vector
// Four products registered, then floored, summed exactly and registered.
// ----------------------------------------------------------------------------
module vt_row_lane #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [3:0][31:0]                  row,
  input  wire logic [3:0][31:0]                  vec,
  output logic signed [vt_pkg::SUM_W-1:0]        sum
);

  logic signed [63:0]              prod [4];
  logic signed [63:0]              shifted [4];
  logic signed [vt_pkg::SUM_W-1:0] sum_next;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        prod[c] <= $signed(row[c]) * $signed(vec[c]);
      end
    end
  end

  // An arithmetic right shift is a floor toward minus infinity.
  always_comb begin
    sum_next = '0;
    for (int c = 0; c < 4; c++) begin
      shifted[c] = prod[c] >>> FRACTION_BITS;
      sum_next   = sum_next + {{(vt_pkg::SUM_W-64){shifted[c][63]}}, shifted[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vt_div_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt_div_lane: pipelined fixed-point divide and saturation of one component
// Restoring division, one quotient bit per stage; non-projective sums and
// zero divisors bypass the quotient and are clamped at the first stage.
// ----------------------------------------------------------------------------
module vt_div_lane #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic                              proj,
  input  wire logic signed [vt_pkg::SUM_W-1:0]   num,
  input  wire logic signed [vt_pkg::SUM_W-1:0]   den,
  output vt_pkg::vt_lane_res_t                   res
);

  localparam int QB = vt_pkg::QB;
  localparam int SW = vt_pkg::SUM_W;
  localparam int CW = SW + FRACTION_BITS + QB;

  typedef struct packed {
    logic [CW-1:0]      rem;
    logic [CW-1:0]      dvs;
    logic [QB-1:0]      q;
    logic               neg;
    logic               ovf;
    logic               byp;
    logic signed [31:0] byp_val;
    logic               byp_sat;
    logic               dz;
  } st_t;

  st_t st [QB+1];
  st_t st0_next;

  logic [SW-1:0] num_mag;
  logic [SW-1:0] den_mag;
  logic          den_zero;

  always_comb begin
    num_mag  = num[SW-1] ? SW'(-num) : SW'(num);
    den_mag  = den[SW-1] ? SW'(-den) : SW'(den);
    den_zero = (den == '0);
    st0_next         = '0;
    st0_next.rem     = CW'(num_mag) << FRACTION_BITS;
    st0_next.dvs     = CW'(den_mag);
    st0_next.neg     = num[SW-1] ^ den[SW-1];
    st0_next.ovf     = (CW'(num_mag) << FRACTION_BITS) >= (CW'(den_mag) << QB);
    st0_next.dz      = proj && den_zero;
    st0_next.byp     = !proj || den_zero;
    if (proj) begin
      // Zero divisor: the sign of the numerator picks the rail.
      st0_next.byp_sat = (num != '0);
      if (num[SW-1]) begin
        st0_next.byp_val = vt_pkg::S32_MIN;
      end else if (num != '0) begin
        st0_next.byp_val = vt_pkg::S32_MAX;
      end else begin
        st0_next.byp_val = '0;
      end
    end else if (num > SW'(vt_pkg::S32_MAX)) begin
      st0_next.byp_val = vt_pkg::S32_MAX;
      st0_next.byp_sat = 1'b1;
    end else if (num < SW'(vt_pkg::S32_MIN)) begin
      st0_next.byp_val = vt_pkg::S32_MIN;
      st0_next.byp_sat = 1'b1;
    end else begin
      st0_next.byp_val = num[31:0];
      st0_next.byp_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int BIT = QB - 1 - k;
    logic [CW-1:0] trial;
    st_t           nxt;
    always_comb begin
      trial = st[k].dvs << BIT;
      nxt   = st[k];
      if (st[k].rem >= trial) begin
        nxt.rem    = st[k].rem - trial;
        nxt.q[BIT] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  logic signed [QB+1:0] mag;
  logic signed [QB+1:0] qval;

  always_comb begin
    mag  = {2'b00, st[QB].q};
    qval = st[QB].neg ? (-mag - (QB+2)'(st[QB].rem != '0)) : mag;
    res.dz = st[QB].dz;
    if (st[QB].byp) begin
      res.val = st[QB].byp_val;
      res.sat = st[QB].byp_sat;
    end else if (st[QB].ovf) begin
      res.val = st[QB].neg ? vt_pkg::S32_MIN : vt_pkg::S32_MAX;
      res.sat = 1'b1;
    end else if (qval > (QB+2)'(vt_pkg::S32_MAX)) begin
      res.val = vt_pkg::S32_MAX;
      res.sat = 1'b1;
    end else if (qval < (QB+2)'(vt_pkg::S32_MIN)) begin
      res.val = vt_pkg::S32_MIN;
      res.sat = 1'b1;
    end else begin
      res.val = qval[31:0];
      res.sat = 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vt_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt_merge: combines the lane results into the output word
// Selects w by mode, gathers the flags and holds the output register.
// ----------------------------------------------------------------------------
module vt_merge #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              vin,
  input  vt_pkg::vt_lane_res_t                   res_x,
  input  vt_pkg::vt_lane_res_t                   res_y,
  input  vt_pkg::vt_lane_res_t                   res_z,
  input  wire logic [1:0]                        op,
  input  wire logic signed [31:0]                in_w,
  input  wire logic signed [vt_pkg::SUM_W-1:0]   sum_w,
  output logic                                   out_valid,
  output vt_pkg::vt_out_t                        out_word
);

  localparam logic signed [31:0] ONE = 32'(1) << FRACTION_BITS;

  vt_pkg::vt_out_t word_next;
  logic            w_sat;

  always_comb begin
    w_sat = 1'b0;
    word_next.out_x = res_x.val;
    word_next.out_y = res_y.val;
    word_next.out_z = res_z.val;
    case (op)
      vt_pkg::OP_HOMO4: begin
        if (sum_w > vt_pkg::SUM_W'(vt_pkg::S32_MAX)) begin
          word_next.out_w = vt_pkg::S32_MAX;
          w_sat = 1'b1;
        end else if (sum_w < vt_pkg::SUM_W'(vt_pkg::S32_MIN)) begin
          word_next.out_w = vt_pkg::S32_MIN;
          w_sat = 1'b1;
        end else begin
          word_next.out_w = sum_w[31:0];
        end
      end
      vt_pkg::OP_AFF4: word_next.out_w = in_w;
      default:         word_next.out_w = ONE;
    endcase
    word_next.divide_by_zero = res_x.dz | res_y.dz | res_z.dz;
    word_next.saturated      = res_x.sat | res_y.sat | res_z.sat | w_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vertex_transform_4x4.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_transform_4x4: 4x4 matrix times vector in signed fixed point
// Four row lanes, three pipelined divide lanes and a merging output stage.
// ----------------------------------------------------------------------------
//  channel  | handshake               | word
//  ---------+-------------------------+------------------------------------
//  input    | in_valid / in_ready     | in_word  (op, in_x..in_w)
//  output   | out_valid / out_ready   | out_word (out_x..out_w, flags)
//  config   | cfg_we                  | cfg_index, cfg_wdata (64 bits)
//
// One word is taken every cycle while the output is not stalled; each word
// passes the row lanes (multiply, sum), then the divide lanes, which
// resolve one quotient bit per stage, and then the output register.
// Reset loads the identity matrix and empties the pipeline.
// A stalled output word halts the whole pipeline, input side included.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  vt_pkg::vt_in_t       in_word,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output vt_pkg::vt_out_t      out_word,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [63:0]     cfg_wdata
);

  localparam int            DL  = vt_pkg::DIV_LAT;
  localparam logic [31:0]   ONE = 32'(1) << FRACTION_BITS;

  typedef struct packed {
    logic [1:0]                       op;
    logic signed [31:0]               in_w;
    logic signed [vt_pkg::SUM_W-1:0]  sum_w;
  } side_t;

  logic [7:0][63:0] mat;
  logic             adv;
  logic [DL+1:0]    vp;

  // Registers listed from index seven down to index zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= {{ONE, 32'h0}, 64'h0, {32'h0, ONE}, 64'h0,
              64'h0, {ONE, 32'h0}, 64'h0, {32'h0, ONE}};
    end else if (cfg_we) begin
      mat[cfg_index] <= cfg_wdata;
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (adv) begin
      vp <= {vp[DL:0], in_valid};
    end
  end

  logic [3:0][31:0]                vec;
  logic signed [vt_pkg::SUM_W-1:0] sums [4];

  assign vec[0] = in_word.in_x;
  assign vec[1] = in_word.in_y;
  assign vec[2] = in_word.in_z;
  assign vec[3] = (in_word.op == vt_pkg::OP_HOMO4 || in_word.op == vt_pkg::OP_AFF4)
                  ? in_word.in_w : ONE;

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic [3:0][31:0] row;
    assign row[0] = mat[2*r][31:0];
    assign row[1] = mat[2*r][63:32];
    assign row[2] = mat[2*r+1][31:0];
    assign row[3] = mat[2*r+1][63:32];
    vt_row_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
      .clk (clk),
      .en  (adv),
      .row (row),
      .vec (vec),
      .sum (sums[r])
    );
  end

  // Mode and w ride alongside the row lanes, then beside the divide lanes.
  logic [1:0]         op_d1, op_d2;
  logic signed [31:0] w_d1, w_d2;
  side_t              dl [DL];

  always_ff @(posedge clk) begin
    if (adv) begin
      op_d1 <= in_word.op;
      w_d1  <= in_word.in_w;
      op_d2 <= op_d1;
      w_d2  <= w_d1;
      dl[0] <= '{op: op_d2, in_w: w_d2, sum_w: sums[3]};
      for (int i = 1; i < DL; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  vt_pkg::vt_lane_res_t res [3];

  for (genvar r = 0; r < 3; r++) begin : g_div
    vt_div_lane #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clk  (clk),
      .en   (adv),
      .proj (op_d2 == vt_pkg::OP_PROJ3),
      .num  (sums[r]),
      .den  (sums[3]),
      .res  (res[r])
    );
  end

  vt_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .vin       (vp[DL+1]),
    .res_x     (res[0]),
    .res_y     (res[1]),
    .res_z     (res[2]),
    .op        (dl[DL-1].op),
    .in_w      (dl[DL-1].in_w),
    .sum_w     (dl[DL-1].sum_w),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_dz_w_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.divide_by_zero |-> out_word.out_w == ONE)
    else $error("divide by zero outside a 3D mode");

  a_dz_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.divide_by_zero |->
      out_word.out_x == 0 || out_word.out_x == vt_pkg::S32_MAX ||
      out_word.out_x == vt_pkg::S32_MIN)
    else $error("zero divisor gave a result off the rails");

  a_dz_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.divide_by_zero && out_word.out_y != 0 |-> out_word.saturated)
    else $error("zero divisor result not flagged as saturated");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for vertex_transform_4x4
// Random and directed vectors are pushed through the transform under several
// matrices and handshake idling patterns; every output word is compared with
// a fixed-point prediction held in a small scoreboard.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] ROW0_LEFT  = 3'd0;
  localparam logic [2:0] ROW0_RIGHT = 3'd1;
  localparam logic [2:0] ROW1_LEFT  = 3'd2;
  localparam logic [2:0] ROW1_RIGHT = 3'd3;
  localparam logic [2:0] ROW2_LEFT  = 3'd4;
  localparam logic [2:0] ROW2_RIGHT = 3'd5;
  localparam logic [2:0] ROW3_LEFT  = 3'd6;
  localparam logic [2:0] ROW3_RIGHT = 3'd7;
  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_WORDS = 190;

  class transform_scoreboard;
    logic [63:0]     matrix[8];
    vt_pkg::vt_out_t pending_results[$];
    int              errors;

    function new();
      matrix[ROW0_LEFT]  = 64'd1 << FRAC;
      matrix[ROW0_RIGHT] = 64'd0;
      matrix[ROW1_LEFT]  = 64'd1 << (FRAC + 32);
      matrix[ROW1_RIGHT] = 64'd0;
      matrix[ROW2_LEFT]  = 64'd0;
      matrix[ROW2_RIGHT] = 64'd1 << FRAC;
      matrix[ROW3_LEFT]  = 64'd0;
      matrix[ROW3_RIGHT] = 64'd1 << (FRAC + 32);
      errors = 0;
    endfunction

    function longint element(int r, int c);
      logic [63:0] w;
      w = matrix[r * 2 + c / 2];
      return longint'($signed(w[(c % 2) * 32 +: 32]));
    endfunction

    // Each product is floored after the shift; the arithmetic shift does that.
    function longint dot_row(int r, longint vec[4]);
      longint acc;
      acc = 0;
      for (int c = 0; c < 4; c++) acc += (element(r, c) * vec[c]) >>> FRAC;
      return acc;
    endfunction

    function logic signed [31:0] clamp(logic signed [127:0] x, inout bit sat);
      if (x > 128'sh7fffffff) begin
        sat = 1;
        return vt_pkg::S32_MAX;
      end
      if (x < -128'sh80000000) begin
        sat = 1;
        return vt_pkg::S32_MIN;
      end
      return x[31:0];
    endfunction

    function logic signed [31:0] quotient(longint num, longint den, inout bit sat);
      logic signed [127:0] n, d, q;
      n = num;
      d = den;
      n = n <<< FRAC;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
      return clamp(q, sat);
    endfunction

    function void note_input(vt_pkg::vt_in_t w);
      longint          vec[4];
      longint          den, num;
      vt_pkg::vt_out_t e;
      bit              sat;
      sat = 0;
      e = '0;
      vec[0] = w.in_x;
      vec[1] = w.in_y;
      vec[2] = w.in_z;
      vec[3] = (w.op == vt_pkg::OP_HOMO4 || w.op == vt_pkg::OP_AFF4)
               ? longint'(w.in_w) : (64'sd1 <<< FRAC);
      if (w.op == vt_pkg::OP_PROJ3) begin
        den = dot_row(3, vec);
        for (int r = 0; r < 3; r++) begin
          logic signed [31:0] v;
          num = dot_row(r, vec);
          if (den == 0) begin
            e.divide_by_zero = 1;
            if (num > 0) begin
              v = vt_pkg::S32_MAX;
              sat = 1;
            end else if (num < 0) begin
              v = vt_pkg::S32_MIN;
              sat = 1;
            end else begin
              v = 0;
            end
          end else begin
            v = quotient(num, den, sat);
          end
          if (r == 0) e.out_x = v;
          else if (r == 1) e.out_y = v;
          else e.out_z = v;
        end
        e.out_w = 32'sd1 <<< FRAC;
      end else begin
        e.out_x = clamp(dot_row(0, vec), sat);
        e.out_y = clamp(dot_row(1, vec), sat);
        e.out_z = clamp(dot_row(2, vec), sat);
        if (w.op == vt_pkg::OP_AFF3) e.out_w = 32'sd1 <<< FRAC;
        else if (w.op == vt_pkg::OP_HOMO4) e.out_w = clamp(dot_row(3, vec), sat);
        else e.out_w = w.in_w;
      end
      e.saturated = sat;
      pending_results.push_back(e);
    endfunction

    function void check_result(vt_pkg::vt_out_t got);
      vt_pkg::vt_out_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.out_x !== e.out_x) begin
        $error("out_x expected %0d got %0d", e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $error("out_y expected %0d got %0d", e.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== e.out_z) begin
        $error("out_z expected %0d got %0d", e.out_z, got.out_z);
        errors++;
      end
      if (got.out_w !== e.out_w) begin
        $error("out_w expected %0d got %0d", e.out_w, got.out_w);
        errors++;
      end
      if (got.divide_by_zero !== e.divide_by_zero) begin
        $error("divide_by_zero expected %0b got %0b", e.divide_by_zero,
               got.divide_by_zero);
        errors++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated expected %0b got %0b", e.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 0;
  logic            rst = 1;
  logic            in_valid = 0;
  logic            in_ready;
  vt_pkg::vt_in_t  in_word = '0;
  logic            out_valid;
  logic            out_ready = 0;
  vt_pkg::vt_out_t out_word;
  logic            cfg_we = 0;
  logic [2:0]      cfg_index = '0;
  logic [63:0]     cfg_wdata = '0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  transform_scoreboard sb = new();

  vertex_transform_4x4 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && in_valid && in_ready) sb.note_input(in_word);
    if (!rst && out_valid && out_ready) sb.check_result(out_word);
  end

  task automatic send_word(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] w);
    vt_pkg::vt_in_t v;
    v.op = op;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_word <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // The first edge lets the scoreboard note the last accepted word.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.matrix[idx] = val;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(0, 1 << 20) - (1 << 19);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3: return $urandom_range(0, 8) << FRAC;
      default: return $urandom_range(0, 1 << 18) - (1 << 17);
    endcase
  endfunction

  task automatic load_matrix(int kind);
    logic [31:0] lo, hi;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        1: begin lo = $urandom(); hi = $urandom(); end
        2: begin lo = $urandom_range(0, 1 << 18) - (1 << 17); hi = pick_value(); end
        3: begin lo = 32'h7fffffff; hi = 32'h7fffffff; end
        4: begin lo = 32'h80000000; hi = 32'h80000000; end
        default: begin
          lo = $urandom_range(0, 1 << 17) - (1 << 16);
          hi = $urandom_range(0, 1 << 17) - (1 << 16);
        end
      endcase
      // A zero bottom row makes every projective divisor zero.
      if (kind == 5 && i >= ROW3_LEFT) begin lo = 0; hi = 0; end
      write_reg(i[2:0], {hi, lo});
    end
    cfg_we <= 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Identity matrix from reset: field extremes in every mode.
    for (int op = 0; op < 4; op++) begin
      send_word(op[1:0], 32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff);
      send_word(op[1:0], 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000);
      send_word(op[1:0], 32'h0, 32'h0, 32'h0, 32'h0);
      send_word(op[1:0], 32'h00018000, 32'hfffe8000, 32'h00000001, 32'hffffffff);
    end
    drain();
    // Zero divisor: a zero bottom row under projective words and one 4D word.
    load_matrix(5);
    send_word(vt_pkg::OP_PROJ3, 32'h00010000, 32'hffff0000, 32'h0, 32'h0);
    send_word(vt_pkg::OP_PROJ3, 32'h0, 32'h0, 32'h0, 32'h12345678);
    send_word(vt_pkg::OP_PROJ3, 32'h80000000, 32'h7fffffff, 32'h00020000, 32'h0);
    send_word(vt_pkg::OP_HOMO4, 32'h00010000, 32'h00010000, 32'h00010000,
              32'h00010000);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) load_matrix((phase + 1) % 6);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        if (n % 48 == 0) begin
          case ((n / 48 + phase) % 5)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            3: begin send_idle_pct = 34; recv_stall_pct = 34; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
          endcase
        end
        if (phase == 2 && n == RANDOM_WORDS / 2) begin
          in_valid <= 0;
          @(posedge clk);
          while (sb.pending_results.size() != 0) @(posedge clk);
        end
        send_word($urandom_range(3), pick_value(), pick_value(), pick_value(), pick_value());
      end
      drain();
    end

    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #1000000;
    $display("tb NOT OK");
    $finish;
  end
endmodule

@@ vertex_transform_4x4.f @@
hw/rtl/vt_pkg.sv
hw/rtl/vt_row_lane.sv
hw/rtl/vt_div_lane.sv
hw/rtl/vt_merge.sv
hw/rtl/vertex_transform_4x4.sv
tb/sv/tb.sv
